/* hdl/mrtu_pkg.sv */
// Shared types, constants and CRC-16 helpers for the Modbus RTU request detector.
`timescale 1ns / 1ps
`default_nettype none

package mrtu_pkg;

    localparam int unsigned SHORT_LEN = 8;
    localparam int unsigned HEAD_LEN  = 7;
    localparam int unsigned CRC_SPAN  = 6;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0]  FC_WRITE_COILS = 8'd15;
    localparam logic [7:0]  FC_WRITE_REGS  = 8'd16;
    localparam logic [15:0] MAX_COILS      = 16'd2000;
    localparam logic [15:0] MAX_REGS       = 16'd125;
    localparam logic [7:0]  CRC_BYTES      = 8'd2;

    typedef struct packed {
        logic        hit;
        logic [7:0]  func;
        logic [15:0] addr;
        logic [15:0] param;
    } mrtu_frame_t;

    typedef struct packed {
        logic       en;
        logic [7:0] idx;
        logic [7:0] data;
    } mrtu_wr_t;

    typedef logic [HEAD_LEN-1:0][15:0] mrtu_chain_t;

    // one byte through the reflected CRC-16
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // CRC of 1..HEAD_LEN zero bytes, used as reset contents of the partial CRC chains
    function automatic mrtu_chain_t zero_chain();
        mrtu_chain_t r;
        logic [15:0] c;
        c = CRC_INIT;
        for (int i = 0; i < HEAD_LEN; i++) begin
            c = crc_feed(c, 8'h00);
            r[i] = c;
        end
        return r;
    endfunction

    localparam mrtu_chain_t ZERO_CHAIN = zero_chain();

endpackage

`default_nettype wire

/* hdl/mrtu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mrtu_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/mrtu_short_det.sv */
// Sliding 8-byte window detector with a pipelined 6-byte CRC chain.
`timescale 1ns / 1ps
`default_nettype none

module mrtu_short_det (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire logic [7:0]           rx_byte,
    input  wire logic [7:0]           slave_address,
    output mrtu_pkg::mrtu_frame_t     res
);
    import mrtu_pkg::*;

    logic [7:0]  sw_reg   [SHORT_LEN];
    logic [15:0] acc_reg  [CRC_SPAN];
    logic [15:0] acc_next [CRC_SPAN];
    logic [15:0] d1_reg;

    // acc_reg[i]: CRC of the last i+1 bytes; d1_reg: CRC of window bytes 1..6
    always_comb
    begin
        acc_next[0] = crc_feed(CRC_INIT, rx_byte);
        for (int i = 1; i < CRC_SPAN; i++) begin
            acc_next[i] = crc_feed(acc_reg[i-1], rx_byte);
        end
    end

    always_comb
    begin
        res.hit   = step && (sw_reg[1] == slave_address) && (d1_reg == {rx_byte, sw_reg[7]});
        res.func  = sw_reg[2];
        res.addr  = {sw_reg[3], sw_reg[4]};
        res.param = {sw_reg[5], sw_reg[6]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SHORT_LEN; i++) begin
                sw_reg[i] <= 8'h00;
            end
            for (int i = 0; i < CRC_SPAN; i++) begin
                acc_reg[i] <= ZERO_CHAIN[i];
            end
            d1_reg <= ZERO_CHAIN[CRC_SPAN-1];
        end
        else if (step)
        begin
            for (int i = 0; i < SHORT_LEN - 1; i++) begin
                sw_reg[i] <= sw_reg[i+1];
            end
            sw_reg[SHORT_LEN-1] <= rx_byte;
            for (int i = 0; i < CRC_SPAN; i++) begin
                acc_reg[i] <= acc_next[i];
            end
            d1_reg <= acc_reg[CRC_SPAN-1];
        end
    end

endmodule

`default_nettype wire

/* hdl/mrtu_long_det.sv */
// Header window, payload capture and running CRC check for function 15/16 requests.
`timescale 1ns / 1ps
`default_nettype none

module mrtu_long_det #(
    parameter int unsigned MAX_CAPTURE_BYTES = 255
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire logic [7:0]           rx_byte,
    input  wire logic [7:0]           slave_address,
    output mrtu_pkg::mrtu_frame_t     res,
    output mrtu_pkg::mrtu_wr_t        wr
);
    import mrtu_pkg::*;

    localparam logic [7:0] MaxCap = 8'(MAX_CAPTURE_BYTES);

    logic [7:0]  hw_reg    [HEAD_LEN];
    logic [7:0]  hw_next   [HEAD_LEN];
    logic [15:0] hacc_reg  [HEAD_LEN];
    logic [15:0] hacc_next [HEAD_LEN];
    logic        capturing_reg;
    logic [7:0]  cnt_reg;
    logic [7:0]  exp_reg;
    logic [15:0] rcrc_reg;
    logic [7:0]  prev_reg;

    logic [7:0]  cnt_inc;
    logic        cap_stop;
    logic        cap_done;
    logic        cap_feed;
    logic        shift_en;
    logic [15:0] qty;
    logic [15:0] qty_round;
    logic        head_hit;

    always_comb
    begin
        for (int i = 0; i < HEAD_LEN - 1; i++) begin
            hw_next[i] = hw_reg[i+1];
        end
        hw_next[HEAD_LEN-1] = rx_byte;
        hacc_next[0] = crc_feed(CRC_INIT, rx_byte);
        for (int i = 1; i < HEAD_LEN; i++) begin
            hacc_next[i] = crc_feed(hacc_reg[i-1], rx_byte);
        end
    end

    always_comb
    begin
        cnt_inc   = cnt_reg + 8'd1;
        cap_stop  = capturing_reg && (cnt_inc >= MaxCap);
        cap_done  = capturing_reg && !cap_stop && (cnt_inc == exp_reg)
                    && (rcrc_reg == {rx_byte, prev_reg});
        cap_feed  = capturing_reg && !cap_stop
                    && (({1'b0, cnt_inc} + {1'b0, CRC_BYTES}) <= {1'b0, exp_reg});
        shift_en  = !capturing_reg || cap_stop;
        qty       = {hw_next[4], hw_next[5]};
        qty_round = qty + 16'd7;
        head_hit  = 1'b0;
        if (hw_next[0] == slave_address)
        begin
            if (hw_next[1] == FC_WRITE_COILS && qty <= MAX_COILS)
                head_hit = (qty_round[10:3] == hw_next[6]);
            else if (hw_next[1] == FC_WRITE_REGS && qty <= MAX_REGS)
                head_hit = ({qty[6:0], 1'b0} == hw_next[6]);
        end
    end

    always_comb
    begin
        res.hit   = step && cap_done;
        res.func  = hw_reg[1];
        res.addr  = {hw_reg[2], hw_reg[3]};
        res.param = {hw_reg[4], hw_reg[5]};
        wr.en     = step && capturing_reg;
        wr.idx    = cnt_reg;
        wr.data   = rx_byte;
    end

    always_ff @(posedge clk)
    begin
        if (step && capturing_reg)
        begin
            prev_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HEAD_LEN; i++) begin
                hw_reg[i]   <= 8'h00;
                hacc_reg[i] <= ZERO_CHAIN[i];
            end
            capturing_reg <= 1'b0;
            cnt_reg       <= 8'd0;
            exp_reg       <= 8'd0;
            rcrc_reg      <= CRC_INIT;
        end
        else if (step)
        begin
            if (capturing_reg)
            begin
                cnt_reg <= cnt_inc;
                if (cap_feed)
                    rcrc_reg <= crc_feed(rcrc_reg, rx_byte);
                if (cap_stop || cap_done)
                    capturing_reg <= 1'b0;
            end
            if (shift_en)
            begin
                for (int i = 0; i < HEAD_LEN; i++) begin
                    hw_reg[i]   <= hw_next[i];
                    hacc_reg[i] <= hacc_next[i];
                end
                if (head_hit)
                begin
                    capturing_reg <= 1'b1;
                    cnt_reg       <= 8'd0;
                    exp_reg       <= hw_next[HEAD_LEN-1] + CRC_BYTES;
                    rcrc_reg      <= hacc_next[HEAD_LEN-1];
                end
            end
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        capturing_reg |-> cnt_reg < MaxCap)
        else $error("capture count reached limit while capturing");

    a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
        capturing_reg |-> (exp_reg >= 8'd2 && exp_reg <= 8'd252))
        else $error("expected length out of range");

    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        res.hit |=> !capturing_reg)
        else $error("capture still active after accepted frame");

endmodule

`default_nettype wire

/* hdl/modbus_rtu_request_detector.sv */
// Top level of the Modbus RTU request detector: handshake, latches and payload RAM.
//
// Usage: the input channel (in_valid / in_stall) carries one transaction per
// received byte (action = 0, rx_byte) or per payload read (action = 1,
// read_index). The output channel (out_valid / out_stall) returns one
// transaction per input: frame_ok, the latched func_code, data_address
// and parameter_res of the last accepted request, and read_data (payload
// byte for reads, zero for received bytes).
// The input is registered in the s1 stage and the result in the output registers.
// One transaction is accepted per cycle while in_stall is low; the per-byte CRC
// and window checks are combinational behind the input register, and the payload
// RAM read data is registered together with the outputs. Reset clears the
// windows, capture state and latches; slave address is 1. Payload RAM content
// is undefined until captured. While out_stall is high the result holds and one
// more input transaction is taken, then in_stall rises. The user must write
// slave_address through cfg_we / cfg_wdata only while idle; this is not enforced.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_request_detector #(
    parameter int unsigned PAYLOAD_DEPTH     = 256,
    parameter int unsigned MAX_CAPTURE_BYTES = 255
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        action,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [7:0]  read_index,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             frame_ok,
    output logic [7:0]       func_code,
    output logic [15:0]      data_address,
    output logic [15:0]      parameter_res,
    output logic [7:0]       read_data
);
    import mrtu_pkg::*;

    localparam int unsigned AddrW = $clog2(PAYLOAD_DEPTH);

    logic        slave_address_reg;
    logic [7:0]  slave_addr_reg;
    logic        s1_valid_reg;
    logic        s1_action_reg;
    logic [7:0]  s1_byte_reg;
    logic [7:0]  s1_index_reg;
    logic        out_valid_reg;
    logic        out_is_read_reg;
    logic        frame_ok_reg;
    logic [7:0]  last_function_reg;
    logic [15:0] last_address_reg;
    logic [15:0] last_parameter_reg;

    logic        out_free;
    logic        s2_adv;
    logic        accept;
    logic        rx_step;
    logic [7:0]  ram_rdata;

    mrtu_frame_t short_res;
    mrtu_frame_t long_res;
    mrtu_wr_t    pay_wr;

    assign out_free = !out_valid_reg || !out_stall;
    assign s2_adv   = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;
    assign rx_step  = s2_adv && !s1_action_reg;

    mrtu_short_det u_short (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (rx_step),
        .rx_byte       (s1_byte_reg),
        .slave_address (slave_addr_reg),
        .res           (short_res)
    );

    mrtu_long_det #(
        .MAX_CAPTURE_BYTES (MAX_CAPTURE_BYTES)
    ) u_long (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (rx_step && !short_res.hit),
        .rx_byte       (s1_byte_reg),
        .slave_address (slave_addr_reg),
        .res           (long_res),
        .wr            (pay_wr)
    );

    mrtu_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_DEPTH)
    ) u_payload (
        .clk   (clk),
        .we    (pay_wr.en),
        .waddr (AddrW'(pay_wr.idx)),
        .wdata (pay_wr.data),
        .re    (s2_adv && s1_action_reg),
        .raddr (AddrW'(s1_index_reg)),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_action_reg <= action;
            s1_byte_reg   <= rx_byte;
            s1_index_reg  <= read_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg  <= 1'b0;
            slave_addr_reg     <= 8'd1;
            s1_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            out_is_read_reg    <= 1'b0;
            frame_ok_reg       <= 1'b0;
            last_function_reg  <= 8'd0;
            last_address_reg   <= 16'd0;
            last_parameter_reg <= 16'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                slave_addr_reg    <= cfg_wdata;
                slave_address_reg <= 1'b1;
            end
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s2_adv)
                s1_valid_reg <= 1'b0;
            if (s2_adv)
            begin
                out_valid_reg   <= 1'b1;
                out_is_read_reg <= s1_action_reg;
                frame_ok_reg    <= short_res.hit || long_res.hit;
                if (short_res.hit)
                begin
                    last_function_reg  <= short_res.func;
                    last_address_reg   <= short_res.addr;
                    last_parameter_reg <= short_res.param;
                end
                else if (long_res.hit)
                begin
                    last_function_reg  <= long_res.func;
                    last_address_reg   <= long_res.addr;
                    last_parameter_reg <= long_res.param;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame_ok      = frame_ok_reg;
    assign func_code     = last_function_reg;
    assign data_address  = last_address_reg;
    assign parameter_res = last_parameter_reg;
    assign read_data     = out_is_read_reg ? ram_rdata : 8'd0;

    a_one_detector: assert property (@(posedge clk) disable iff (!rst_n)
        !(short_res.hit && long_res.hit))
        else $error("both detectors fired on one byte");

    a_hold_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_adv) |=> s1_valid_reg)
        else $error("held transaction dropped");

    a_read_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_adv && s1_action_reg) |=> (out_valid_reg && !frame_ok_reg))
        else $error("read transaction reported a frame");

    a_cfg_seen: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (slave_address_reg && slave_addr_reg == $past(cfg_wdata)))
        else $error("slave address write lost");

endmodule

`default_nettype wire
